FILE: rtl/ccr_pkg.sv
package ccr_pkg;

  // Icon and frame geometry.
  localparam int unsigned ICON_SIZE     = 64;
  localparam int unsigned CHANNELS      = 4;
  localparam int unsigned MAX_DIMENSION = 4096;

  // Field widths fixed by the interface.
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned FIRST_W = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // Quotients of the span division never exceed ICON_SIZE.
  localparam int unsigned QUOT_W = $clog2(ICON_SIZE + 1);
  localparam int unsigned NUM_W  = DIM_W + QUOT_W;
  localparam int unsigned STEP_W = $clog2(QUOT_W);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PIXEL_W-1:0] PIXEL_MASK = (CHANNELS >= 4) ? {PIXEL_W{1'b1}} :
      PIXEL_W'((64'd1 << (8 * CHANNELS)) - 64'd1);

  localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(64);
  localparam bit               DIM_CAPPED = (MAX_DIMENSION < (1 << DIM_W));
  localparam logic [DIM_W-1:0] DIM_LIMIT  = DIM_W'(MAX_DIMENSION);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_e;

  // One classified pixel as handed from the front part to the back part.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               in_crop;
    logic [DIM_W-1:0]   u_x;
    logic [DIM_W-1:0]   u_y;
    logic [DIM_W-1:0]   side;
    logic               eof;
    logic               frame_bad;
  } ccr_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } span_ctrl_t;

  // Register values above the supported dimension act as the limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    if (DIM_CAPPED && (v > DIM_LIMIT)) begin
      return DIM_LIMIT;
    end
    return v;
  endfunction

endpackage

FILE: rtl/ccr_span.sv
module ccr_span (
  input  logic                       clk_i,
  input  ccr_pkg::span_ctrl_t        ctrl_i,
  input  logic [ccr_pkg::DIM_W-1:0]  u_i,
  input  logic [ccr_pkg::DIM_W-1:0]  side_i,
  output logic [ccr_pkg::FIRST_W-1:0] first_o,
  output logic [ccr_pkg::COUNT_W-1:0] count_o
);
  import ccr_pkg::*;

  // Two restoring-division lanes sharing one divisor shift register:
  // first = ceil(u*ICON/side), end = ceil((u+1)*ICON/side).
  logic [NUM_W-1:0]  rem_f_q, rem_f_d, rem_e_q, rem_e_d, div_q, div_d;
  logic [QUOT_W-1:0] quo_f_q, quo_f_d, quo_e_q, quo_e_d;
  logic [NUM_W-1:0]  num_f, num_e;
  logic [QUOT_W-1:0] span_end, span_first;

  assign num_f = NUM_W'(u_i) * NUM_W'(ICON_SIZE) + NUM_W'(side_i) - NUM_W'(1);
  assign num_e = num_f + NUM_W'(ICON_SIZE);

  always_comb begin
    rem_f_d = rem_f_q;
    rem_e_d = rem_e_q;
    quo_f_d = quo_f_q;
    quo_e_d = quo_e_q;
    div_d   = div_q;
    if (ctrl_i.load) begin
      rem_f_d = num_f;
      rem_e_d = num_e;
      quo_f_d = '0;
      quo_e_d = '0;
      div_d   = NUM_W'(side_i) << (QUOT_W - 1);
    end else if (ctrl_i.step) begin
      if (rem_f_q >= div_q) begin
        rem_f_d = rem_f_q - div_q;
        quo_f_d = {quo_f_q[QUOT_W-2:0], 1'b1};
      end else begin
        quo_f_d = {quo_f_q[QUOT_W-2:0], 1'b0};
      end
      if (rem_e_q >= div_q) begin
        rem_e_d = rem_e_q - div_q;
        quo_e_d = {quo_e_q[QUOT_W-2:0], 1'b1};
      end else begin
        quo_e_d = {quo_e_q[QUOT_W-2:0], 1'b0};
      end
      div_d = div_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_f_q <= rem_f_d;
    rem_e_q <= rem_e_d;
    quo_f_q <= quo_f_d;
    quo_e_q <= quo_e_d;
    div_q   <= div_d;
  end

  always_comb begin
    span_end   = (quo_e_q > QUOT_W'(ICON_SIZE)) ? QUOT_W'(ICON_SIZE) : quo_e_q;
    span_first = (quo_f_q > span_end) ? span_end : quo_f_q;
    first_o    = FIRST_W'(span_first);
    count_o    = COUNT_W'(span_end - span_first);
  end

endmodule

FILE: rtl/ccr_front.sv
module ccr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ccr_pkg::PIXEL_W-1:0] pixel_i,
  input  logic                        end_of_frame_i,
  input  logic [ccr_pkg::DIM_W-1:0]   frame_width_i,
  input  logic [ccr_pkg::DIM_W-1:0]   frame_height_i,
  input  logic                        full_i,
  output logic                        push_o,
  output ccr_pkg::ccr_item_t          item_o
);
  import ccr_pkg::*;

  logic [DIM_W-1:0] col_q, col_d, row_q, row_d;
  logic             overrun_q, overrun_d;
  logic [DIM_W-1:0] w, h, side, diff, x0, y0, col_rel, row_rel;
  logic [DIM_W:0]   col_inc, row_inc;
  logic             accept, w_gt_h, overrun_now, in_x, in_y, in_crop, wrap, exact_end;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    w           = eff_dim(frame_width_i);
    h           = eff_dim(frame_height_i);
    overrun_now = (w == '0) || (h == '0) || (row_q >= h);
    w_gt_h      = w > h;
    side        = w_gt_h ? h : w;
    diff        = w_gt_h ? (w - h) : (h - w);
    x0          = w_gt_h ? (diff >> 1) : '0;
    y0          = w_gt_h ? '0 : (diff >> 1);
    col_rel     = col_q - x0;
    row_rel     = row_q - y0;
    in_x        = (col_q >= x0) && (col_rel < side);
    in_y        = (row_q >= y0) && (row_rel < side);
    in_crop     = !overrun_now && in_x && in_y;
    col_inc     = {1'b0, col_q} + (DIM_W+1)'(1);
    row_inc     = {1'b0, row_q} + (DIM_W+1)'(1);
    wrap        = col_inc >= {1'b0, w};
    exact_end   = !overrun_now && (row_inc == {1'b0, h}) && (col_inc == {1'b0, w});
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    overrun_d = overrun_q;
    if (accept) begin
      if (end_of_frame_i) begin
        col_d     = '0;
        row_d     = '0;
        overrun_d = 1'b0;
      end else if (overrun_now) begin
        overrun_d = 1'b1;
      end else if (wrap) begin
        col_d = '0;
        row_d = row_inc[DIM_W-1:0];
      end else begin
        col_d = col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      overrun_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      overrun_q <= overrun_d;
    end
  end

  // Only pixels inside the crop or the end-of-frame beat can give a result.
  assign push_o = accept && (in_crop || end_of_frame_i);

  always_comb begin
    item_o.pixel     = pixel_i & PIXEL_MASK;
    item_o.in_crop   = in_crop;
    item_o.u_x       = col_rel;
    item_o.u_y       = row_rel;
    item_o.side      = side;
    item_o.eof       = end_of_frame_i;
    item_o.frame_bad = end_of_frame_i && (overrun_q || overrun_now || !exact_end);
  end

endmodule

FILE: rtl/ccr_queue.sv
module ccr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ccr_pkg::ccr_item_t item_i,
  input  logic               pop_i,
  output ccr_pkg::ccr_item_t head_o,
  output logic               full_o,
  output logic               empty_o
);
  import ccr_pkg::*;

  ccr_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/ccr_back.sv
module ccr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccr_pkg::ccr_item_t           head_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ccr_pkg::PIXEL_W-1:0]  icon_pixel_o,
  output logic [ccr_pkg::FIRST_W-1:0]  target_x_first_o,
  output logic [ccr_pkg::COUNT_W-1:0]  target_x_count_o,
  output logic [ccr_pkg::FIRST_W-1:0]  target_y_first_o,
  output logic [ccr_pkg::COUNT_W-1:0]  target_y_count_o,
  output logic                         frame_bad_o,
  output logic                         last_o
);
  import ccr_pkg::*;

  bk_state_e         state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  ccr_item_t         item_q;
  span_ctrl_t        span_ctrl;
  logic [FIRST_W-1:0] x_first, y_first;
  logic [COUNT_W-1:0] x_count, y_count;
  logic              out_valid_q, out_free, emit, need_out, out_load;

  ccr_span u_span_x (
    .clk_i   (clk_i),
    .ctrl_i  (span_ctrl),
    .u_i     (head_i.u_x),
    .side_i  (head_i.side),
    .first_o (x_first),
    .count_o (x_count)
  );

  ccr_span u_span_y (
    .clk_i   (clk_i),
    .ctrl_i  (span_ctrl),
    .u_i     (head_i.u_y),
    .side_i  (head_i.side),
    .first_o (y_first),
    .count_o (y_count)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = item_q.in_crop && (x_count != '0) && (y_count != '0);
  assign need_out = emit || item_q.eof;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      BK_IDLE: begin
        step_d = STEP_W'(QUOT_W - 1);
        if (!empty_i) begin
          state_d = head_i.in_crop ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!need_out || out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o          = 1'b0;
    span_ctrl.load = 1'b0;
    span_ctrl.step = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_o          = !empty_i;
        span_ctrl.load = !empty_i;
      end
      BK_DIV: begin
        span_ctrl.step = 1'b1;
      end
      BK_DONE: begin
        out_load = need_out && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= (out_valid_q && !out_ready_i) || out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
    end
    if (out_load) begin
      icon_pixel_o     <= emit ? item_q.pixel : '0;
      target_x_first_o <= emit ? x_first : '0;
      target_x_count_o <= emit ? x_count : '0;
      target_y_first_o <= emit ? y_first : '0;
      target_y_count_o <= emit ? y_count : '0;
      frame_bad_o      <= item_q.frame_bad;
      last_o           <= item_q.eof;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/center_crop_nearest_resize_core.sv
// Timing: with the back part idle, a taken beat is written into the queue; the back part pops it in BK_IDLE,
// steps the span dividers in BK_DIV if the pixel lies in the crop, and loads the registered output beat in BK_DONE.
// Throughput: pixels that give no result are taken one per cycle while the queue has room; a
// pixel inside the crop holds the back part through the span division (one quotient bit per
// cycle) and BK_DONE, an end-of-frame beat outside the crop through BK_DONE, which waits while the output stalls.
// Reset: rst_ni is asynchronous and active low; it clears the frame position, the queue and the
// output beat, and sets both frame dimension registers to 64.
module center_crop_nearest_resize_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ccr_pkg::ADDR_W-1:0]   paddr,
  input  logic [ccr_pkg::DATA_W-1:0]   pwdata,
  output logic [ccr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // Pixel input.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ccr_pkg::PIXEL_W-1:0]  pixel_i,
  input  logic                         end_of_frame_i,
  // Icon result output.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ccr_pkg::PIXEL_W-1:0]  icon_pixel_o,
  output logic [ccr_pkg::FIRST_W-1:0]  target_x_first_o,
  output logic [ccr_pkg::COUNT_W-1:0]  target_x_count_o,
  output logic [ccr_pkg::FIRST_W-1:0]  target_y_first_o,
  output logic [ccr_pkg::COUNT_W-1:0]  target_y_count_o,
  output logic                         frame_bad_o,
  output logic                         last_o
);
  import ccr_pkg::*;

  // The frame is center-cropped to a square on its short side, and each icon cell samples
  // the crop pixel at floor(t*side/ICON_SIZE). The front part tracks the raster position,
  // decides whether a pixel lies in the crop, and works out the frame_bad flag at the
  // end-of-frame beat. Pixels that can give a result travel through a short queue to the
  // back part, which divides to find the run of icon columns and rows that sample the pixel
  // and sends out one beat when both runs are non-empty, or always for the end-of-frame beat.

  logic [DIM_W-1:0] frame_width_q, frame_height_q;
  logic             cfg_write;
  reg_index_e       cfg_index;
  logic [DIM_W-1:0] rd_value;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_RESET;
      frame_height_q <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_FRAME_WIDTH:  rd_value = frame_width_q;
      REG_FRAME_HEIGHT: rd_value = frame_height_q;
      default:          rd_value = '0;
    endcase
    prdata = DATA_W'(rd_value);
  end

  // Front part: position tracking and classification.
  ccr_item_t front_item, head_item;
  logic      push, pop, q_full, q_empty;

  ccr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .end_of_frame_i (end_of_frame_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .full_i         (q_full),
    .push_o         (push),
    .item_o         (front_item)
  );

  // The queue lets the front keep taking pixels while the dividers are busy.
  ccr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back part: span division and the registered output beat.
  ccr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_item),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .icon_pixel_o     (icon_pixel_o),
    .target_x_first_o (target_x_first_o),
    .target_x_count_o (target_x_count_o),
    .target_y_first_o (target_y_first_o),
    .target_y_count_o (target_y_count_o),
    .frame_bad_o      (frame_bad_o),
    .last_o           (last_o)
  );

endmodule

FILE: rtl/ccr_checker.sv
module ccr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [ccr_pkg::PIXEL_W-1:0]  icon_pixel_o,
  input logic [ccr_pkg::FIRST_W-1:0]  target_x_first_o,
  input logic [ccr_pkg::COUNT_W-1:0]  target_x_count_o,
  input logic [ccr_pkg::FIRST_W-1:0]  target_y_first_o,
  input logic [ccr_pkg::COUNT_W-1:0]  target_y_count_o,
  input logic                         frame_bad_o,
  input logic                         last_o
);

  // A stalled result beat holds its pixel, counts, frame_bad and last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(icon_pixel_o) && $stable(last_o)
      && $stable(target_x_count_o) && $stable(target_y_count_o) && $stable(frame_bad_o))
    else $error("result beat changed while stalled");

  // A bad frame is only reported on the end-of-frame beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_bad_o |-> last_o)
    else $error("frame_bad outside the last beat");

  // Any beat other than the last one fills at least one icon cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> (target_x_count_o != '0) && (target_y_count_o != '0))
    else $error("non-last beat fills no icon cell");

  // An empty x span marks an unsampled end-of-frame beat with zero pixel, firsts and counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (target_x_count_o == '0) |-> (target_y_count_o == '0)
      && (target_x_first_o == '0) && (target_y_first_o == '0) && (icon_pixel_o == '0))
    else $error("unsampled beat carries nonzero fields");

endmodule

bind center_crop_nearest_resize_core ccr_checker u_ccr_checker (.*);
